// ===== rtl/core/bcs_pkg.sv =====
// Shared constants and types for the Bhabha cross-section pipeline.
// Used by bcs_log and bhabha_cross_section_unit in rtl/core; depends on nothing.
package bcs_pkg;

    localparam int E_W     = 24;   // positron and minimum energy, Q8.16 MeV
    localparam int SCALE_W = 32;   // scale factor, Q8.24
    localparam int CS_W    = 32;   // cross section, Q16.16
    localparam int CFG_W   = 32;   // configuration write data

    // Electron mass 0.511 MeV in Q8.16.
    localparam logic [15:0] EMASS   = 16'd33489;
    // ln 2 in Q0.32.
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    // ceil(2^35 / 3): floor(x / 3) == (x * RECIP3) >> 35 for any x below 2^35.
    localparam logic [33:0] RECIP3  = 34'd11453246123;
    localparam int RECIP3_SHIFT     = 35;

    localparam int MUL_LAT   = 3;
    localparam int LOG_STEPS = 32;
    localparam int LOG_LAT   = 2 + LOG_STEPS + MUL_LAT;

    // 1/xi is at least 2^33 and below 2^56 in Q32.32; its log is below 2^37.
    localparam int IXI_W = 56;
    localparam int IXI_MIN_MSB = 33;
    localparam int LNV_W = 37;

    // Bit positions in m_tuser.
    localparam int USER_BELOW = 0;
    localparam int USER_SAT   = 1;

    typedef enum logic [0:0] {
        REG_MIN_DELTA_ENERGY = 1'b0,
        REG_SCALE_FACTOR     = 1'b1
    } cfg_reg_t;

endpackage

// ===== rtl/core/bcs_delay.sv =====
// Enabled delay line that carries an operand alongside the pipeline.
// Stand-alone; no package needed.
module bcs_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

// ===== rtl/core/bcs_mul.sv =====
// Three-stage unsigned multiplier built from four 32x32 partial products.
// Stand-alone; operands up to 64 bits each.
module bcs_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [WA-1:0]      a,
    input  logic [WB-1:0]      b,
    output logic [WA+WB-1:0]   p
);

    logic [63:0]  a64;
    logic [63:0]  b64;
    logic [63:0]  ll_reg;
    logic [63:0]  lh_reg;
    logic [63:0]  hl_reg;
    logic [63:0]  hh_reg;
    logic [127:0] mid_reg;
    logic [63:0]  hh2_reg;
    logic [127:0] p_reg;

    assign a64 = 64'(a);
    assign b64 = 64'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg  <= a64[31:0]  * b64[31:0];
            lh_reg  <= a64[31:0]  * b64[63:32];
            hl_reg  <= a64[63:32] * b64[31:0];
            hh_reg  <= a64[63:32] * b64[63:32];
            mid_reg <= 128'(ll_reg) + (128'(lh_reg) << 32) + (128'(hl_reg) << 32);
            hh2_reg <= hh_reg;
            p_reg   <= mid_reg + (128'(hh2_reg) << 64);
        end
    end

    assign p = p_reg[WA+WB-1:0];

endmodule

// ===== rtl/core/bcs_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// Stand-alone. Expects num < den * 2^QW; ovf flags the case where it is not.
module bcs_div #(
    parameter int WN = 48,
    parameter int WD = 25,
    parameter int QW = 32
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [WN-1:0] num,
    input  logic [WD-1:0] den,
    output logic [QW-1:0] quo,
    output logic          ovf
);

    localparam int WT = WN - QW;
    localparam int WC = (WT > WD) ? WT : WD;

    logic [WT-1:0] top_bits;
    logic          ovf_in;

    logic [WD-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [WD-1:0] den_reg [QW];
    logic          ovf_reg [QW];

    assign top_bits = num[WN-1:QW];
    assign ovf_in   = (WC'(top_bits) >= WC'(den));

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [WD-1:0] rem_i;
        logic [QW-1:0] quo_i;
        logic [QW-1:0] low_i;
        logic [WD-1:0] den_i;
        logic          ovf_i;
        logic [WD:0]   trial;
        logic [WD:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_i = WD'(top_bits);
            assign quo_i = '0;
            assign low_i = num[QW-1:0];
            assign den_i = den;
            assign ovf_i = ovf_in;
        end else begin : g_next
            assign rem_i = rem_reg[k-1];
            assign quo_i = quo_reg[k-1];
            assign low_i = low_reg[k-1];
            assign den_i = den_reg[k-1];
            assign ovf_i = ovf_reg[k-1];
        end

        assign trial = {rem_i, low_i[QW-1]};
        assign diff  = trial - {1'b0, den_i};
        assign ge    = (trial >= {1'b0, den_i});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[WD-1:0] : trial[WD-1:0];
                quo_reg[k] <= {quo_i[QW-2:0], ge};
                low_reg[k] <= {low_i[QW-2:0], 1'b0};
                den_reg[k] <= den_i;
                ovf_reg[k] <= ovf_i;
            end
        end
    end

    assign quo = quo_reg[QW-1];
    assign ovf = ovf_reg[QW-1];

endmodule

// ===== rtl/core/bcs_log.sv =====
// Natural logarithm of 1/xi (Q32.32 in, Q32.32 out) by repeated squaring.
// Uses bcs_pkg and bcs_mul.
module bcs_log (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [bcs_pkg::IXI_W-1:0]  x,
    output logic [bcs_pkg::LNV_W-1:0]  lnv
);
    import bcs_pkg::*;

    logic [5:0]       msb;
    logic [5:0]       msb_reg;
    logic [IXI_W-1:0] xa_reg;
    logic [30:0]      m0_reg;
    logic [4:0]       ip0_reg;

    logic [30:0]      msq_reg  [LOG_STEPS];
    logic [31:0]      frac_reg [LOG_STEPS];
    logic [4:0]       ip_reg   [LOG_STEPS];

    logic [LNV_W+31:0] prod;

    // Leading one; the value is at least 2^33 so the search starts there.
    always_comb begin
        msb = 6'(IXI_MIN_MSB);
        for (int i = IXI_MIN_MSB; i < IXI_W; i++) begin
            if (x[i]) begin
                msb = 6'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            msb_reg <= msb;
            xa_reg  <= x;
            // Mantissa in Q1.30 with its leading one at bit 30.
            m0_reg  <= 31'(xa_reg >> (msb_reg - 6'd30));
            ip0_reg <= 5'(msb_reg - 6'd32);
        end
    end

    for (genvar k = 0; k < LOG_STEPS; k++) begin : g_sq
        logic [30:0] m_i;
        logic [31:0] frac_i;
        logic [4:0]  ip_i;
        logic [61:0] sq;
        logic [31:0] sq_q;
        logic [31:0] frac_n;

        if (k == 0) begin : g_first
            assign m_i    = m0_reg;
            assign frac_i = '0;
            assign ip_i   = ip0_reg;
        end else begin : g_next
            assign m_i    = msq_reg[k-1];
            assign frac_i = frac_reg[k-1];
            assign ip_i   = ip_reg[k-1];
        end

        assign sq   = m_i * m_i;
        assign sq_q = sq[61:30];

        always_comb begin
            frac_n = frac_i;
            frac_n[LOG_STEPS-1-k] = sq_q[31];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                // A square of two or more gives a one in the next fraction bit.
                msq_reg[k]  <= sq_q[31] ? sq_q[31:1] : sq_q[30:0];
                frac_reg[k] <= frac_n;
                ip_reg[k]   <= ip_i;
            end
        end
    end

    bcs_mul #(.WA(LNV_W), .WB(32)) u_ln2 (
        .aclk (aclk),
        .en   (en),
        .a    ({ip_reg[LOG_STEPS-1], frac_reg[LOG_STEPS-1]}),
        .b    (LN2_Q32),
        .p    (prod)
    );

    assign lnv = prod[LNV_W+31:32];

endmodule

// ===== rtl/core/bhabha_cross_section_unit.sv =====
// Bhabha total cross section: positron energy in, cross section and flags out.
// Throughput: one item per cycle while no result waits; the pipeline is set by the
// 56-bit 1/xi divider, the 32 squaring stages of the logarithm and the final 33-bit
// division. The whole pipeline stalls while a result waits; reset clears the valid
// bits and both configuration registers.
module bhabha_cross_section_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bcs_pkg::E_W-1:0]      s_tdata,   // [23:0] positron_energy
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bcs_pkg::CS_W-1:0]     m_tdata,   // [31:0] cross_section
    output logic [1:0]                   m_tuser,   // [0] below_threshold, [1] saturated
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_index,
    input  logic [bcs_pkg::CFG_W-1:0]    cfg_data
);
    import bcs_pkg::*;

    // Divider widths (Q_) and pipeline schedule (T_): the stage at which each value sits in a register.
    localparam int Q_Y   = 32;
    localparam int Q_IB2 = 45;
    localparam int Q_XI  = 32;
    localparam int Q_IXI = 56;
    localparam int Q_FIN = 33;
    localparam int T_XI  = Q_XI;
    localparam int T_IXI = Q_IXI;
    localparam int T_Y   = 1 + Q_Y;
    localparam int T_IB2 = 1 + Q_IB2;
    localparam int T_B1  = T_Y + MUL_LAT;
    localparam int T_B4  = T_B1 + MUL_LAT;
    localparam int T_B43 = T_B4 + MUL_LAT;
    localparam int T_X2  = T_XI + MUL_LAT;
    localparam int T_X3  = T_X2 + MUL_LAT;
    localparam int T_P   = T_IXI;
    localparam int T_T   = T_P + MUL_LAT;
    localparam int T_POS = T_T + 1;
    localparam int T_LN  = T_P + LOG_LAT;
    localparam int T_T5  = T_LN + MUL_LAT;
    localparam int T_NEG = T_T5 + 1;
    localparam int T_SIG = T_NEG + 1;
    localparam int T_FM  = T_SIG + MUL_LAT;
    localparam int T_Q   = T_FM + Q_FIN;
    localparam int T_OUT = T_Q + 1;

    logic                 en;
    logic [T_OUT:0]       vld_reg;

    logic [E_W-1:0]       emin_reg;
    logic [SCALE_W-1:0]   scale_reg;

    logic [E_W-1:0]       e0_reg;
    logic [24:0]          sa;
    logic [24:0]          dy;
    logic [24:0]          dy_reg;
    logic [49:0]          sq_reg;
    logic [48:0]          dib_reg;

    logic [31:0]          y;
    logic [44:0]          ib2;
    logic [31:0]          xi;
    logic [IXI_W-1:0]     ixi;

    logic [32:0]          b0;
    logic [63:0]          y2_p;
    logic [65:0]          b0sq_p;
    logic [31:0]          y_d;
    logic [32:0]          b0_d;
    logic [32:0]          b0sq;
    logic [33:0]          c3;
    logic [33:0]          tw;
    logic [33:0]          b1;
    logic [66:0]          b2_p;
    logic [66:0]          b3_p;
    logic [65:0]          b4_p;
    logic [66:0]          b43_pr;
    logic [33:0]          b2;
    logic [33:0]          b3;
    logic [32:0]          b4;
    logic [32:0]          b3_2;
    logic [31:0]          b4_3;

    logic [63:0]          xi2_p;
    logic [63:0]          xi3_p;
    logic [31:0]          xi_d3;

    logic [44:0]          ib2_p;
    logic [33:0]          b2_pd;
    logic [31:0]          xi_p;
    logic [31:0]          xi2_pd;
    logic [32:0]          b32_p;
    logic [31:0]          xi3_pd;
    logic [31:0]          b43_p;
    logic [31:0]          b43_t;

    logic [100:0]         t1_p;
    logic [66:0]          t2_p;
    logic [64:0]          t4_p;
    logic [63:0]          t6_p;
    logic [63:0]          pos_reg;
    logic [63:0]          pos_d;

    logic [LNV_W-1:0]     lnv;
    logic [33:0]          b1_l;
    logic [70:0]          t5_p;
    logic [32:0]          b32_n;
    logic [63:0]          t6_d;
    logic [63:0]          neg_reg;
    logic [63:0]          sigma_reg;

    logic [95:0]          fin_p;
    logic [E_W-1:0]       e_f;
    logic [E_W-1:0]       e_o;
    logic [32:0]          quo;
    logic                 quo_ovf;

    logic [CS_W-1:0]      cs_reg;
    logic                 below_reg;
    logic                 sat_reg;

    // Every stage moves together; a waiting result holds the whole pipeline.
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            emin_reg  <= '0;
            scale_reg <= '0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[T_OUT-1:0], s_tvalid};
            end
            if (cfg_valid) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MIN_DELTA_ENERGY: begin
                        emin_reg <= cfg_data[E_W-1:0];
                    end
                    REG_SCALE_FACTOR: begin
                        scale_reg <= cfg_data[SCALE_W-1:0];
                    end
                endcase
            end
        end
    end

    // Stage 0 and 1: energy, then E+m squared and E(E+2m).
    assign sa = 25'(e0_reg) + 25'(EMASS);
    assign dy = 25'(e0_reg) + 25'({EMASS, 1'b0});

    always_ff @(posedge aclk) begin
        if (en) begin
            e0_reg  <= s_tdata;
            dy_reg  <= dy;
            sq_reg  <= sa * sa;
            dib_reg <= e0_reg * dy;
        end
    end

    bcs_div #(.WN(48), .WD(25), .QW(Q_Y)) u_div_y (
        .aclk (aclk), .en (en), .num ({EMASS, 32'h0}), .den (dy_reg),
        .quo (y), .ovf ()
    );

    bcs_div #(.WN(82), .WD(49), .QW(Q_IB2)) u_div_ib2 (
        .aclk (aclk), .en (en), .num ({sq_reg, 32'h0}), .den (dib_reg),
        .quo (ib2), .ovf ()
    );

    bcs_div #(.WN(56), .WD(E_W), .QW(Q_XI)) u_div_xi (
        .aclk (aclk), .en (en), .num ({emin_reg, 32'h0}), .den (e0_reg),
        .quo (xi), .ovf ()
    );

    bcs_div #(.WN(57), .WD(E_W), .QW(Q_IXI)) u_div_ixi (
        .aclk (aclk), .en (en), .num ({1'b0, e0_reg, 32'h0}), .den (emin_reg),
        .quo (ixi), .ovf ()
    );

    // Coefficients b0..b4 from y.
    assign b0 = 33'h1_0000_0000 - {y, 1'b0};

    bcs_mul #(.WA(32), .WB(32)) u_y2 (
        .aclk (aclk), .en (en), .a (y), .b (y), .p (y2_p)
    );
    bcs_mul #(.WA(33), .WB(33)) u_b0sq (
        .aclk (aclk), .en (en), .a (b0), .b (b0), .p (b0sq_p)
    );
    bcs_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_y (
        .aclk (aclk), .en (en), .d (y), .q (y_d)
    );
    bcs_delay #(.WIDTH(33), .DEPTH(MUL_LAT)) u_dly_b0 (
        .aclk (aclk), .en (en), .d (b0), .q (b0_d)
    );

    assign b0sq = b0sq_p[64:32];
    assign c3   = 34'h3_0000_0000 + 34'(y2_p[63:32]);
    assign tw   = 34'h2_0000_0000 - {1'b0, y_d, 1'b0};
    assign b1   = 34'h2_0000_0000 - 34'(y2_p[63:32]);

    bcs_mul #(.WA(33), .WB(34)) u_b2 (
        .aclk (aclk), .en (en), .a (b0_d), .b (c3), .p (b2_p)
    );
    bcs_mul #(.WA(34), .WB(33)) u_b3 (
        .aclk (aclk), .en (en), .a (tw), .b (b0sq), .p (b3_p)
    );
    bcs_mul #(.WA(33), .WB(33)) u_b4 (
        .aclk (aclk), .en (en), .a (b0sq), .b (b0_d), .p (b4_p)
    );

    assign b2   = b2_p[65:32];
    assign b3   = b3_p[65:32];
    assign b4   = b4_p[64:32];
    assign b3_2 = b3[33:1];

    bcs_mul #(.WA(33), .WB(34)) u_b43 (
        .aclk (aclk), .en (en), .a (b4), .b (RECIP3), .p (b43_pr)
    );
    assign b4_3 = b43_pr[RECIP3_SHIFT+31:RECIP3_SHIFT];

    // Powers of xi.
    bcs_mul #(.WA(32), .WB(32)) u_xi2 (
        .aclk (aclk), .en (en), .a (xi), .b (xi), .p (xi2_p)
    );
    bcs_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_xi3 (
        .aclk (aclk), .en (en), .d (xi), .q (xi_d3)
    );
    bcs_mul #(.WA(32), .WB(32)) u_xi3 (
        .aclk (aclk), .en (en), .a (xi2_p[63:32]), .b (xi_d3), .p (xi3_p)
    );

    // Align the operands of the main products with 1/xi.
    bcs_delay #(.WIDTH(45), .DEPTH(T_P - T_IB2)) u_dly_ib2 (
        .aclk (aclk), .en (en), .d (ib2), .q (ib2_p)
    );
    bcs_delay #(.WIDTH(34), .DEPTH(T_P - T_B4)) u_dly_b2 (
        .aclk (aclk), .en (en), .d (b2), .q (b2_pd)
    );
    bcs_delay #(.WIDTH(32), .DEPTH(T_P - T_XI)) u_dly_xi (
        .aclk (aclk), .en (en), .d (xi), .q (xi_p)
    );
    bcs_delay #(.WIDTH(32), .DEPTH(T_P - T_X2)) u_dly_xi2 (
        .aclk (aclk), .en (en), .d (xi2_p[63:32]), .q (xi2_pd)
    );
    bcs_delay #(.WIDTH(33), .DEPTH(T_P - T_B4)) u_dly_b32 (
        .aclk (aclk), .en (en), .d (b3_2), .q (b32_p)
    );
    bcs_delay #(.WIDTH(32), .DEPTH(T_P - T_X3)) u_dly_xi3p (
        .aclk (aclk), .en (en), .d (xi3_p[63:32]), .q (xi3_pd)
    );
    bcs_delay #(.WIDTH(32), .DEPTH(T_P - T_B43)) u_dly_b43 (
        .aclk (aclk), .en (en), .d (b4_3), .q (b43_p)
    );
    bcs_delay #(.WIDTH(32), .DEPTH(T_T - T_P)) u_dly_b43t (
        .aclk (aclk), .en (en), .d (b43_p), .q (b43_t)
    );

    bcs_mul #(.WA(45), .WB(IXI_W)) u_t1 (
        .aclk (aclk), .en (en), .a (ib2_p),
        .b (IXI_W'(ixi - 56'h1_0000_0000)), .p (t1_p)
    );
    bcs_mul #(.WA(34), .WB(33)) u_t2 (
        .aclk (aclk), .en (en), .a (b2_pd),
        .b (33'h1_0000_0000 - 33'(xi_p)), .p (t2_p)
    );
    bcs_mul #(.WA(32), .WB(33)) u_t4 (
        .aclk (aclk), .en (en), .a (xi2_pd), .b (b32_p), .p (t4_p)
    );
    bcs_mul #(.WA(32), .WB(32)) u_t6 (
        .aclk (aclk), .en (en), .a (xi3_pd), .b (b43_p), .p (t6_p)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg <= t1_p[95:32] + 64'(t2_p[66:32]) + 64'(b43_t) + 64'(t4_p[64:32]);
        end
    end

    // Logarithm branch and the negative terms.
    bcs_log u_log (
        .aclk (aclk), .en (en), .x (ixi), .lnv (lnv)
    );
    bcs_delay #(.WIDTH(34), .DEPTH(T_LN - T_B1)) u_dly_b1 (
        .aclk (aclk), .en (en), .d (b1), .q (b1_l)
    );
    bcs_mul #(.WA(34), .WB(LNV_W)) u_t5 (
        .aclk (aclk), .en (en), .a (b1_l), .b (lnv), .p (t5_p)
    );
    bcs_delay #(.WIDTH(33), .DEPTH(T_T5 - T_P)) u_dly_b32n (
        .aclk (aclk), .en (en), .d (b32_p), .q (b32_n)
    );
    bcs_delay #(.WIDTH(64), .DEPTH(T_T5 - T_T)) u_dly_t6 (
        .aclk (aclk), .en (en), .d (64'(t6_p[63:32])), .q (t6_d)
    );
    bcs_delay #(.WIDTH(64), .DEPTH(T_NEG - T_POS)) u_dly_pos (
        .aclk (aclk), .en (en), .d (pos_reg), .q (pos_d)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg   <= 64'(t5_p[70:32]) + 64'(b32_n) + t6_d;
            // Truncation can push sigma below zero; it is clamped there.
            sigma_reg <= (pos_d > neg_reg) ? (pos_d - neg_reg) : '0;
        end
    end

    // Scale, then divide by E * 2^24.
    bcs_mul #(.WA(64), .WB(SCALE_W)) u_fin (
        .aclk (aclk), .en (en), .a (sigma_reg), .b (scale_reg), .p (fin_p)
    );
    bcs_delay #(.WIDTH(E_W), .DEPTH(T_FM)) u_dly_ef (
        .aclk (aclk), .en (en), .d (e0_reg), .q (e_f)
    );
    bcs_div #(.WN(72), .WD(E_W), .QW(Q_FIN)) u_div_fin (
        .aclk (aclk), .en (en), .num (fin_p[95:24]), .den (e_f),
        .quo (quo), .ovf (quo_ovf)
    );
    bcs_delay #(.WIDTH(E_W), .DEPTH(T_Q - T_FM)) u_dly_eo (
        .aclk (aclk), .en (en), .d (e_f), .q (e_o)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            if (e_o <= {emin_reg, 1'b0}) begin
                cs_reg    <= '0;
                below_reg <= 1'b1;
                sat_reg   <= 1'b0;
            end else if (emin_reg == '0 || quo_ovf || quo[32]) begin
                // A zero minimum energy diverges and is reported as full scale.
                cs_reg    <= '1;
                below_reg <= 1'b0;
                sat_reg   <= 1'b1;
            end else begin
                cs_reg    <= quo[31:0];
                below_reg <= 1'b0;
                sat_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid           = vld_reg[T_OUT];
    assign m_tdata            = cs_reg;
    assign m_tuser[USER_BELOW] = below_reg;
    assign m_tuser[USER_SAT]   = sat_reg;

    a_below_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_BELOW] |-> !m_tuser[USER_SAT] && m_tdata == '0)
        else $error("below-threshold result carries data or saturation");

    a_sat_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_SAT] |-> m_tdata == '1)
        else $error("saturated result is not full scale");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

endmodule

// ===== test/bhabha_cross_section_unit_tb.sv =====
// Self-checking testbench for bhabha_cross_section_unit: random and directed energies
// are streamed in, every result is compared with a bit-exact fixed-point predictor.
// Depends on rtl/core/bcs_pkg.sv and rtl/core/bhabha_cross_section_unit.sv.
`timescale 1ns / 1ps

module bhabha_cross_section_unit_tb;
    import bcs_pkg::*;

    localparam logic [63:0] Q_ONE    = 64'h1_0000_0000;
    localparam logic [63:0] ALL_ONES = '1;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic [CS_W-1:0] xsec;
        logic            below;
        logic            sat;
    } xsec_result_t;

    class xsec_board;
        logic [E_W-1:0]     emin;
        logic [SCALE_W-1:0] scale;
        xsec_result_t       awaited[$];
        int                 mismatches;

        function new();
            emin = '0;
            scale = '0;
            mismatches = 0;
        endfunction

        function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            if (p[127:96] != 0) return ALL_ONES;
            return p[95:32];
        endfunction

        function logic [63:0] qdiv(logic [63:0] a, logic [63:0] b);
            logic [127:0] q;
            if (b == 0) return ALL_ONES;
            q = {32'd0, a, 32'd0} / {64'd0, b};
            if (q[127:64] != 0) return ALL_ONES;
            return q[63:0];
        endfunction

        function logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? ALL_ONES : s[63:0];
        endfunction

        // Natural log in Q32.32, via log2 by repeated squaring of the mantissa.
        function logic [63:0] qlog(logic [63:0] x);
            int          p;
            logic [63:0] mant;
            logic [31:0] frac;
            logic [31:0] ipart;
            if (x < Q_ONE) return 0;
            p = 63;
            while (p > 32 && !x[p]) p--;
            mant = x >> (p - 30);
            frac = '0;
            for (int k = 0; k < 32; k++) begin
                mant = (mant * mant) >> 30;
                if (mant >= (64'd2 << 30)) begin
                    mant = mant >> 1;
                    frac[31-k] = 1'b1;
                end
            end
            ipart = p - 32;
            return qmul({ipart, frac}, {32'd0, LN2_Q32});
        endfunction

        function xsec_result_t predict(logic [E_W-1:0] energy);
            xsec_result_t r;
            logic [63:0] e, em, m, y, y2, ib2, b0, b1, b2, b3, b4, b0sq, b4_3, b3_2;
            logic [63:0] xi, ixi, xi2, xi3, lnv, pos, neg, sigma;
            logic [127:0] q;
            r.xsec = '0;
            r.below = 1'b0;
            r.sat = 1'b0;
            e = energy;
            em = emin;
            m = EMASS;
            if (e <= 2 * em) begin
                r.below = 1'b1;
                return r;
            end
            if (em == 0) begin
                r.xsec = '1;
                r.sat = 1'b1;
                return r;
            end
            y    = qdiv(m, e + 2 * m);
            ib2  = qdiv((e + m) * (e + m), e * (e + 2 * m));
            y2   = qmul(y, y);
            b0   = Q_ONE - 2 * y;
            b1   = 2 * Q_ONE - y2;
            b2   = qmul(b0, 3 * Q_ONE + y2);
            b0sq = qmul(b0, b0);
            b3   = qmul(2 * (Q_ONE - y), b0sq);
            b4   = qmul(b0sq, b0);
            b4_3 = b4 / 3;
            b3_2 = b3 >> 1;
            xi   = qdiv(em, e);
            ixi  = qdiv(e, em);
            xi2  = qmul(xi, xi);
            xi3  = qmul(xi2, xi);
            lnv  = qlog(ixi);
            pos = sadd(sadd(qmul(ib2, ixi - Q_ONE), qmul(b2, Q_ONE - xi)),
                       sadd(b4_3, qmul(xi2, b3_2)));
            neg = sadd(sadd(qmul(b1, lnv), b3_2), qmul(xi3, b4_3));
            sigma = (pos > neg) ? pos - neg : 64'd0;
            q = ({64'd0, sigma} * {96'd0, scale}) / {64'd0, (e << 24)};
            if (q > 128'hFFFF_FFFF) begin
                r.xsec = '1;
                r.sat = 1'b1;
            end else begin
                r.xsec = q[31:0];
            end
            return r;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
            if (idx == REG_MIN_DELTA_ENERGY) emin = value[E_W-1:0];
            else scale = value;
        endfunction

        function void note_input(logic [E_W-1:0] energy);
            awaited.push_back(predict(energy));
        endfunction

        function void check_result(logic [CS_W-1:0] xsec, logic [1:0] user);
            xsec_result_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: xsec=%h user=%b", xsec, user);
                return;
            end
            want = awaited.pop_front();
            if (xsec !== want.xsec || user[USER_BELOW] !== want.below
                    || user[USER_SAT] !== want.sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected xsec=%h below=%b sat=%b, ",
                              "got xsec=%h user=%b"},
                             want.xsec, want.below, want.sat, xsec, user);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [E_W-1:0]    s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [CS_W-1:0]   m_tdata;
    logic [1:0]        m_tuser;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [0:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    xsec_board board;
    bit        idling_on;
    bit        hold_request;
    bit        hold_done;
    int        idle_cycles;
    logic [E_W-1:0] emin_now;

    bhabha_cross_section_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Every handshake is seen here with the values from before the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_reg(cfg_reg_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready) board.note_input(s_tdata);
            if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls while idling_on is set, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request && !hold_done) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [E_W-1:0] emin, logic [SCALE_W-1:0] scale);
        write_reg(REG_MIN_DELTA_ENERGY, emin);
        write_reg(REG_SCALE_FACTOR, scale);
        emin_now = emin;
    endtask

    task automatic send_energy(logic [E_W-1:0] energy);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= energy;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Pause the sender until every awaited result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic logic [E_W-1:0] random_energy();
        logic [25:0] near;
        case ($urandom_range(0, 9)) inside
            0, 1: begin
                near = 26'(2 * emin_now + $urandom_range(0, 3));
                return (near > 26'hFFFFFF) ? E_W'($urandom_range(0, 24'hFFFFFF))
                                           : near[E_W-1:0];
            end
            2: return E_W'($urandom_range(0, 4 * emin_now + 16));
            3: return 24'hFFFFFF - E_W'($urandom_range(0, 15));
            default: return E_W'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    task automatic random_phase(int count, bit long_hold);
        for (int i = 0; i < count; i++) begin
            if (long_hold && i == count / 2) hold_request = 1'b1;
            send_energy(random_energy());
        end
        drain();
    endtask

    initial begin
        board = new();
        idling_on = 1'b1;
        emin_now = '0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: zero minimum means every energy above zero diverges.
        send_energy(24'h000000);
        send_energy(24'h000001);
        send_energy(24'hFFFFFF);
        drain();

        set_config(24'h000001, 32'hFFFFFFFF);
        send_energy(24'h000002);
        send_energy(24'h000003);
        send_energy(24'h800000);
        send_energy(24'hFFFFFF);
        drain();

        set_config(24'h7FFFFF, 32'h01000000);
        send_energy(24'h000000);
        send_energy(24'hFFFFFE);
        send_energy(24'hFFFFFF);
        drain();

        set_config(24'hFFFFFF, 32'h00000000);
        send_energy(24'hFFFFFF);
        send_energy(24'h555555);
        drain();

        set_config(24'h000800, 32'h00000001);
        send_energy(24'h001000);
        send_energy(24'h001001);
        send_energy(24'h123456);
        send_energy(24'hAAAAAA);
        drain();

        set_config(24'h00199A, 32'h0C000000);
        random_phase(260, 1'b1);
        set_config(E_W'($urandom_range(1, 24'h00FFFF)), $urandom());
        random_phase(260, 1'b0);
        set_config(E_W'($urandom_range(1, 24'h3FFFFF)), $urandom());
        random_phase(260, 1'b0);
        set_config(E_W'($urandom_range(1, 24'h000FFF)), 32'hFFFFFFFF);
        random_phase(260, 1'b0);
        set_config(E_W'($urandom_range(24'h400000, 24'hFFFFFF)), $urandom());
        random_phase(200, 1'b0);
        set_config(E_W'($urandom_range(1, 24'h07FFFF)), $urandom());
        idling_on = 1'b0;
        random_phase(360, 1'b0);

        if (board.mismatches == 0 && board.awaited.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
